// ===== rtl/ddts_pkg.sv =====
`timescale 1ns / 1ps

package ddts_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned ActionW = 2;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [TimeW-1:0] MinPrimaryMs   = TimeW'(60000);
  localparam logic [TimeW-1:0] SecResetMs     = TimeW'(60000);
  localparam logic [TimeW-1:0] WaitForever    = '1;

  localparam logic [CfgIdxW-1:0] RegPrimaryIvl   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegSecondaryIvl = CfgIdxW'(1);

  typedef enum logic [ActionW-1:0] {
    ACT_NONE      = 2'd0,
    ACT_PRIMARY   = 2'd1,
    ACT_SECONDARY = 2'd2
  } action_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             armed;
    logic             disabled;
    logic             secondary_enabled;
    logic             fire_now_request;
    logic             interval_changed;
    logic             secondary_kick;
  } tick_t;

  typedef struct packed {
    action_e          action;
    logic [TimeW-1:0] wait_ms;
  } result_t;

endpackage

// ===== rtl/ddts_if.sv =====
`timescale 1ns / 1ps

// Tick channel
interface ddts_in_if;
  logic                         valid;
  logic                         ready;
  logic [ddts_pkg::TimeW-1:0]   now_ms;
  logic                         armed;
  logic                         disabled;
  logic                         secondary_enabled;
  logic                         fire_now_request;
  logic                         interval_changed;
  logic                         secondary_kick;

  modport source (output valid, now_ms, armed, disabled, secondary_enabled,
                  fire_now_request, interval_changed, secondary_kick,
                  input ready);
  modport sink   (input valid, now_ms, armed, disabled, secondary_enabled,
                  fire_now_request, interval_changed, secondary_kick,
                  output ready);
endinterface

// Result channel
interface ddts_out_if;
  logic                         valid;
  logic                         ready;
  logic [ddts_pkg::ActionW-1:0] action;
  logic [ddts_pkg::TimeW-1:0]   wait_ms;

  modport source (output valid, action, wait_ms, input ready);
  modport sink   (input valid, action, wait_ms, output ready);
endinterface

// Register write channel
interface ddts_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ddts_pkg::CfgIdxW-1:0] index;
  logic [ddts_pkg::TimeW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/dual_deadline_task_scheduler.sv =====
`timescale 1ns / 1ps
// A transferred tick is captured in the input register, then its decision is stored
//   in the result register, which drives the result channel.
// Throughput: one tick per cycle, limited only by result back-pressure.
// Reset (rst_ni, async, active low): deadlines and flags clear, both
//   intervals return to 60000 ms, both pipeline stages empty.

module dual_deadline_task_scheduler (
  input  logic      clk_i,
  input  logic      rst_ni,
  ddts_in_if.sink   in_i,
  ddts_out_if.source out_o,
  ddts_cfg_if.sink  cfg_i
);
  import ddts_pkg::*;

  // Interval registers; the user must write config only while idle (not enforced here).
  logic [TimeW-1:0] pri_ivl_q, pri_ivl_d;
  logic [TimeW-1:0] sec_ivl_q, sec_ivl_d;

  // Stage 1: captured tick
  tick_t   tick_q;
  logic    tick_valid_q;

  // Stage 2: result register
  result_t res_q;
  result_t res_d;
  logic    res_valid_q;

  logic    advance;
  logic    in_xfer;

  // Stage 1 moves on whenever the result register is free or being drained.
  assign advance  = tick_valid_q & (~res_valid_q | out_o.ready);
  assign in_i.ready = ~tick_valid_q | advance;
  assign in_xfer  = in_i.valid & in_i.ready;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    pri_ivl_d = pri_ivl_q;
    sec_ivl_d = sec_ivl_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegPrimaryIvl: begin
          // Primary period never drops below the one-minute floor.
          pri_ivl_d = (cfg_i.data < MinPrimaryMs) ? MinPrimaryMs : cfg_i.data;
        end
        RegSecondaryIvl: begin
          sec_ivl_d = cfg_i.data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pri_ivl_q <= MinPrimaryMs;
      sec_ivl_q <= SecResetMs;
    end else begin
      pri_ivl_q <= pri_ivl_d;
      sec_ivl_q <= sec_ivl_d;
    end
  end

  // Deadline state and the per-tick schedule decision
  ddts_sched_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .tick_i    (tick_q),
    .pri_ivl_i (pri_ivl_q),
    .sec_ivl_i (sec_ivl_q),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        tick_valid_q <= 1'b1;
      end else if (advance) begin
        tick_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tick_q.now_ms            <= in_i.now_ms;
      tick_q.armed             <= in_i.armed;
      tick_q.disabled          <= in_i.disabled;
      tick_q.secondary_enabled <= in_i.secondary_enabled;
      tick_q.fire_now_request  <= in_i.fire_now_request;
      tick_q.interval_changed  <= in_i.interval_changed;
      tick_q.secondary_kick    <= in_i.secondary_kick;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid   = res_valid_q;
  assign out_o.action  = res_q.action;
  assign out_o.wait_ms = res_q.wait_ms;

endmodule

// ===== rtl/ddts_sched_core.sv =====
`timescale 1ns / 1ps

module ddts_sched_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  ddts_pkg::tick_t            tick_i,
  input  logic [ddts_pkg::TimeW-1:0] pri_ivl_i,
  input  logic [ddts_pkg::TimeW-1:0] sec_ivl_i,
  output ddts_pkg::result_t          result_o
);
  import ddts_pkg::*;

  logic [TimeW-1:0] pri_dl_q, pri_dl_d;
  logic [TimeW-1:0] sec_dl_q, sec_dl_d;
  logic             was_armed_q, was_armed_d;
  logic             fire_now_q, fire_now_d;

  logic             fire, arm_edge;
  logic [TimeW-1:0] now, pri_sum, sec_sum;
  logic [TimeW-1:0] pri_diff, sec_diff, pri_gap, sec_gap;

  // A deadline set to now + ivl is due at once when ivl is zero or above 2^31.
  logic             pri_ahead_due, sec_ahead_due;
  logic [TimeW-1:0] pri_ahead_wait, sec_ahead_wait;

  logic [TimeW-1:0] pri_eff, sec_eff;
  logic             pri_due, sec_due;
  logic [TimeW-1:0] pri_wait, sec_wait;
  logic [TimeW-1:0] pw, sw;

  assign now      = tick_i.now_ms;
  assign fire     = fire_now_q | tick_i.fire_now_request;
  assign arm_edge = tick_i.armed & ~was_armed_q;
  assign pri_sum  = now + pri_ivl_i;
  assign sec_sum  = now + sec_ivl_i;
  assign pri_diff = now - pri_dl_q;
  assign sec_diff = now - sec_dl_q;
  assign pri_gap  = pri_dl_q - now;
  assign sec_gap  = sec_dl_q - now;

  assign pri_ahead_due  = (pri_ivl_i == '0) ||
                          (pri_ivl_i[TimeW-1] && (pri_ivl_i[TimeW-2:0] != '0));
  assign sec_ahead_due  = (sec_ivl_i == '0) ||
                          (sec_ivl_i[TimeW-1] && (sec_ivl_i[TimeW-2:0] != '0));
  assign pri_ahead_wait = pri_ahead_due ? '0 : pri_ivl_i;
  assign sec_ahead_wait = sec_ahead_due ? '0 : sec_ivl_i;

  // Deadlines after arming, interval change and kick, with their due flags
  always_comb begin
    if ((tick_i.armed && tick_i.interval_changed) || (arm_edge && !fire)) begin
      pri_eff  = pri_sum;
      pri_due  = pri_ahead_due;
      pri_wait = pri_ahead_wait;
    end else if (arm_edge) begin
      pri_eff  = now;
      pri_due  = 1'b1;
      pri_wait = '0;
    end else begin
      pri_eff  = pri_dl_q;
      pri_due  = ~pri_diff[TimeW-1];
      pri_wait = pri_diff[TimeW-1] ? pri_gap : '0;
    end

    if (arm_edge && !(fire && tick_i.secondary_enabled)) begin
      sec_eff  = sec_sum;
      sec_due  = sec_ahead_due;
      sec_wait = sec_ahead_wait;
    end else if (arm_edge || tick_i.secondary_kick) begin
      sec_eff  = now;
      sec_due  = 1'b1;
      sec_wait = '0;
    end else begin
      sec_eff  = sec_dl_q;
      sec_due  = ~sec_diff[TimeW-1];
      sec_wait = sec_diff[TimeW-1] ? sec_gap : '0;
    end
  end

  always_comb begin
    pri_dl_d    = pri_eff;
    sec_dl_d    = sec_eff;
    was_armed_d = tick_i.armed;
    fire_now_d  = arm_edge ? 1'b0 : fire;
    result_o.action  = ACT_NONE;
    result_o.wait_ms = '0;
    pw = pri_wait;
    sw = sec_wait;

    if (!tick_i.armed) begin
      result_o.wait_ms = WaitForever;
    end else if (tick_i.disabled) begin
      // Expired deadlines slide one interval past now; the secondary only while enabled.
      if (pri_due) begin
        pri_dl_d = pri_sum;
        pw       = pri_ahead_wait;
      end
      if (tick_i.secondary_enabled && sec_due) begin
        sec_dl_d = sec_sum;
        sw       = sec_ahead_wait;
      end
      result_o.wait_ms = (tick_i.secondary_enabled && (sw < pw)) ? sw : pw;
    end else if (pri_due) begin
      result_o.action = ACT_PRIMARY;
      pri_dl_d        = pri_sum;
    end else if (tick_i.secondary_enabled && sec_due) begin
      result_o.action = ACT_SECONDARY;
      sec_dl_d        = sec_sum;
    end else begin
      result_o.wait_ms = (tick_i.secondary_enabled && (sw < pw)) ? sw : pw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pri_dl_q    <= '0;
      sec_dl_q    <= '0;
      was_armed_q <= 1'b0;
      fire_now_q  <= 1'b0;
    end else if (step_i) begin
      pri_dl_q    <= pri_dl_d;
      sec_dl_q    <= sec_dl_d;
      was_armed_q <= was_armed_d;
      fire_now_q  <= fire_now_d;
    end
  end

endmodule
